@@ rtl/core/windowed_amplitude_tracker_macros.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef WINDOWED_AMPLITUDE_TRACKER_MACROS_SVH
`define WINDOWED_AMPLITUDE_TRACKER_MACROS_SVH

`ifndef SYNTH
// Same-cycle check.
`define WAT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("wat check failed");
// Next-cycle check: cons must hold in the cycle after ante.
`define WAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wat check failed");
`else
`define WAT_ASSERT(lbl, clk, rstn, prop)
`define WAT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/wat_pkg.sv @@
package wat_pkg;

    localparam int WINDOW      = 400;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;
    localparam int PTR_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int SUM_W       = MAG_W + CNT_W;
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * MAG_W;

    // ceil(2^k / WINDOW): exact floor division for any sum below 2^SUM_W
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_FULL[RECIP_W-1:0];
    localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]   FILL_FULL = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]   FILL_EDGE = CNT_W'(WINDOW - 1);

    // sample in flight between the input register and the accumulator
    typedef struct packed {
        logic             last;
        logic [MAG_W-1:0] mag;
        logic [PTR_W-1:0] slot;
        logic             old_full;   // line was full before this sample
        logic             new_full;   // line is full after this sample
    } t_stage;

    // per-clip summary handed to the result stage
    typedef struct packed {
        logic [SUM_W-1:0] best;
        logic [MAG_W-1:0] peak;
        logic             enough;
    } t_clip;

    // |sample|, with the most negative code saturated
    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
        logic [MAG_W-1:0] inv;
        inv = ~s[MAG_W-1:0] + MAG_W'(1);
        if (!s[SAMPLE_W-1]) begin
            return s[MAG_W-1:0];
        end else if (s[MAG_W-1:0] == '0) begin
            return '1;
        end else begin
            return inv;
        end
    endfunction

endpackage

@@ rtl/core/wat_line.sv @@
module wat_line (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [wat_pkg::PTR_W-1:0] i_rd_addr,
    output logic [wat_pkg::MAG_W-1:0] o_rd_data,
    input  logic                      i_wr_en,
    input  logic [wat_pkg::PTR_W-1:0] i_wr_addr,
    input  logic [wat_pkg::MAG_W-1:0] i_wr_data
);

    logic [wat_pkg::MAG_W-1:0] r_mem [wat_pkg::WINDOW];
    logic [wat_pkg::MAG_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/wat_front.sv @@
`include "windowed_amplitude_tracker_macros.svh"

module wat_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [wat_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_last,
    input  logic                         i_clip_free,
    output logic                         o_ready,
    output logic                         o_fire,
    output wat_pkg::t_stage              o_stage,
    output logic                         o_rd_en,
    output logic [wat_pkg::PTR_W-1:0]    o_rd_addr
);

    logic                      r_valid;
    logic                      r_last;
    logic [wat_pkg::MAG_W-1:0] r_mag;
    logic [wat_pkg::PTR_W-1:0] r_slot;
    logic                      r_old_full;
    logic                      r_new_full;
    logic [wat_pkg::PTR_W-1:0] r_ptr;
    logic [wat_pkg::CNT_W-1:0] r_fill;
    logic [wat_pkg::PTR_W-1:0] n_ptr;
    logic [wat_pkg::CNT_W-1:0] n_fill;
    logic                      drain;
    logic                      acc;
    logic                      old_full;
    logic                      new_full;

    // a clip end may only leave the stage when the result side has room
    assign drain    = !r_valid || !r_last || i_clip_free;
    assign acc      = i_valid && drain;
    assign old_full = (r_fill == wat_pkg::FILL_FULL);
    assign new_full = old_full || (r_fill == wat_pkg::FILL_EDGE);

    always_comb begin
        n_ptr  = (r_ptr == wat_pkg::LAST_SLOT) ? '0 : r_ptr + wat_pkg::PTR_W'(1);
        n_fill = old_full ? r_fill : r_fill + wat_pkg::CNT_W'(1);
        if (i_last) begin
            n_ptr  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ptr   <= '0;
            r_fill  <= '0;
        end else begin
            if (drain) begin
                r_valid <= i_valid;
            end
            if (acc) begin
                r_ptr  <= n_ptr;
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_last     <= i_last;
            r_mag      <= wat_pkg::magnitude(i_sample);
            r_slot     <= r_ptr;
            r_old_full <= old_full;
            r_new_full <= new_full;
        end
    end

    assign o_ready   = drain;
    assign o_fire    = r_valid && drain;
    assign o_rd_en   = acc;
    assign o_rd_addr = r_ptr;

    assign o_stage.last     = r_last;
    assign o_stage.mag      = r_mag;
    assign o_stage.slot     = r_slot;
    assign o_stage.old_full = r_old_full;
    assign o_stage.new_full = r_new_full;

    `WAT_ASSERT(a_fill_range, i_clk, i_rst_n, r_fill <= wat_pkg::FILL_FULL)
    `WAT_ASSERT_NEXT(a_clip_restart, i_clk, i_rst_n, acc && i_last, r_fill == '0 && r_ptr == '0)

endmodule

@@ rtl/core/wat_accum.sv @@
`include "windowed_amplitude_tracker_macros.svh"

module wat_accum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wat_pkg::t_stage           i_stage,
    input  logic                      i_fire,
    input  logic [wat_pkg::MAG_W-1:0] i_rd_data,
    output logic                      o_wr_en,
    output logic [wat_pkg::PTR_W-1:0] o_wr_addr,
    output logic [wat_pkg::MAG_W-1:0] o_wr_data,
    output logic                      o_clip_valid,
    output wat_pkg::t_clip            o_clip
);

    logic [wat_pkg::SUM_W-1:0] r_sum;
    logic [wat_pkg::SUM_W-1:0] r_best;
    logic [wat_pkg::MAG_W-1:0] r_peak;
    logic [wat_pkg::SUM_W-1:0] n_sum;
    logic [wat_pkg::SUM_W-1:0] n_best;
    logic [wat_pkg::MAG_W-1:0] n_peak;
    logic [wat_pkg::SUM_W-1:0] drop;

    // oldest magnitude leaves the window once the line is full
    assign drop   = i_stage.old_full ? wat_pkg::SUM_W'(i_rd_data) : '0;
    assign n_sum  = r_sum - drop + wat_pkg::SUM_W'(i_stage.mag);
    assign n_best = (i_stage.new_full && n_sum > r_best) ? n_sum : r_best;
    assign n_peak = (i_stage.mag > r_peak) ? i_stage.mag : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_best <= '0;
            r_peak <= '0;
        end else if (i_fire) begin
            if (i_stage.last) begin
                r_sum  <= '0;
                r_best <= '0;
                r_peak <= '0;
            end else begin
                r_sum  <= n_sum;
                r_best <= n_best;
                r_peak <= n_peak;
            end
        end
    end

    assign o_wr_en   = i_fire;
    assign o_wr_addr = i_stage.slot;
    assign o_wr_data = i_stage.mag;

    // short clip reports all zeros; best is still zero then
    assign o_clip_valid  = i_fire && i_stage.last;
    assign o_clip.best   = n_best;
    assign o_clip.peak   = i_stage.new_full ? n_peak : '0;
    assign o_clip.enough = i_stage.new_full;

    `WAT_ASSERT_NEXT(a_clip_clear, i_clk, i_rst_n, o_clip_valid,
        r_sum == '0 && r_best == '0 && r_peak == '0)
    `WAT_ASSERT(a_short_zero, i_clk, i_rst_n,
        !(o_clip_valid && !o_clip.enough) || (o_clip.best == '0 && o_clip.peak == '0))

endmodule

@@ rtl/core/wat_result.sv @@
`include "windowed_amplitude_tracker_macros.svh"

module wat_result (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clip_valid,
    input  wat_pkg::t_clip            i_clip,
    input  logic                      i_m_ready,
    output logic                      o_free,
    output logic                      o_valid,
    output logic [wat_pkg::MAG_W-1:0] o_peak,
    output logic [wat_pkg::MAG_W-1:0] o_average,
    output logic                      o_enough
);

    logic                         r_r_valid;
    wat_pkg::t_clip               r_r;
    logic                         r_o_valid;
    logic [wat_pkg::MAG_W-1:0]    r_o_peak;
    logic [wat_pkg::MAG_W-1:0]    r_o_average;
    logic                         r_o_enough;
    logic                         o_room;
    logic                         move;
    logic [wat_pkg::PROD_W-1:0]   prod;
    logic [wat_pkg::MAG_W-1:0]    quot;

    assign o_room = !r_o_valid || i_m_ready;
    assign move   = r_r_valid && o_room;
    assign o_free = !r_r_valid || o_room;

    // best / WINDOW by reciprocal multiply, exact over the sum range
    assign prod = wat_pkg::PROD_W'(r_r.best) * wat_pkg::PROD_W'(wat_pkg::RECIP);
    assign quot = wat_pkg::MAG_W'(prod >> wat_pkg::RECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_r_valid <= i_clip_valid || (r_r_valid && !o_room);
            if (o_room) begin
                r_o_valid <= r_r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clip_valid) begin
            r_r <= i_clip;
        end
        if (move) begin
            r_o_peak    <= r_r.peak;
            r_o_average <= quot;
            r_o_enough  <= r_r.enough;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_peak    = r_o_peak;
    assign o_average = r_o_average;
    assign o_enough  = r_o_enough;

    `WAT_ASSERT_NEXT(a_mid_hold, i_clk, i_rst_n, r_r_valid && !o_room,
        r_r_valid && $stable(r_r))

endmodule

@@ rtl/core/windowed_amplitude_tracker.sv @@
// A clip's result reaches o_m_tvalid through the front, summary and output registers.
// Throughput: one sample per cycle; a clip end waits only when two results are already queued.
// The rate is set by one delay-line read and one write per sample plus one sum update.
// Reset (i_rst_n, synchronous, active low) clears handshakes, sums, peak, pointer and fill count.
// The delay-line RAM is not cleared; entries are used only after being written in the same clip.
module windowed_amplitude_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [wat_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [15:0] sample
    input  logic                            i_s_tlast,   // last sample of clip
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wat_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // [14:0] peak, [29:15] average
    output logic                            o_m_tuser    // [0] enough
);

    // Pipeline:
    //   front  - registers the sample as a magnitude, steps pointer and fill
    //            count, and issues the delay-line read for the slot it
    //            will overwrite
    //   line   - WINDOW-deep magnitude RAM, registered read
    //   accum  - running window sum, best full-window sum and peak; writes
    //            the new magnitude back and emits a clip summary on last
    //   result - two-entry queue: summary register, then divide-by-WINDOW
    //            into the output register

    logic                      clip_free;
    logic                      fire;
    wat_pkg::t_stage           stage;
    logic                      rd_en;
    logic [wat_pkg::PTR_W-1:0] rd_addr;
    logic [wat_pkg::MAG_W-1:0] rd_data;
    logic                      wr_en;
    logic [wat_pkg::PTR_W-1:0] wr_addr;
    logic [wat_pkg::MAG_W-1:0] wr_data;
    logic                      clip_valid;
    wat_pkg::t_clip            clip;
    logic [wat_pkg::MAG_W-1:0] res_peak;
    logic [wat_pkg::MAG_W-1:0] res_average;
    logic                      res_enough;

    wat_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_sample    (i_s_tdata[wat_pkg::SAMPLE_W-1:0]),
        .i_last      (i_s_tlast),
        .i_clip_free (clip_free),
        .o_ready     (o_s_tready),
        .o_fire      (fire),
        .o_stage     (stage),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    // Read of the next slot never collides with the write of the current
    // one within a clip: consecutive samples use adjacent slots.
    wat_line u_line (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    wat_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (stage),
        .i_fire       (fire),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_clip_valid (clip_valid),
        .o_clip       (clip)
    );

    wat_result u_result (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clip_valid (clip_valid),
        .i_clip       (clip),
        .i_m_ready    (i_m_tready),
        .o_free       (clip_free),
        .o_valid      (o_m_tvalid),
        .o_peak       (res_peak),
        .o_average    (res_average),
        .o_enough     (res_enough)
    );

    assign o_m_tdata = {{wat_pkg::OUT_PAD_W{1'b0}}, res_average, res_peak};
    assign o_m_tuser = res_enough;

endmodule

@@ bench/testbench.sv @@
module testbench;

    // Cycles with no request moving on either side before the run is declared hung.
    // The longest correct quiet stretch is the forced hold-off below plus pipeline latency,
    // so this leaves plenty of margin.
    localparam int STALL_LIMIT      = 2000;
    localparam int HOLD_OFF         = 300;   // forced sink hold-off, in cycles
    localparam int RANDOM_SAMPLES   = 220;
    localparam int MIN_RANDOM_CLIPS = 8;
    localparam int DRAIN_CYCLES     = 12;
    localparam int REPORT_LIMIT     = 10;

    // One clip summary as it leaves the block.
    typedef struct packed {
        logic [wat_pkg::MAG_W-1:0] peak;
        logic [wat_pkg::MAG_W-1:0] average;
        logic                      enough;
    } t_clip_summary;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [wat_pkg::IN_TDATA_W-1:0]  i_s_tdata;   // [15:0] sample
    logic                            i_s_tlast;   // last sample of clip
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [wat_pkg::OUT_TDATA_W-1:0] o_m_tdata;   // [14:0] peak, [29:15] average, [31:30] zero
    logic                            o_m_tuser;   // [0] enough

    windowed_amplitude_tracker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_clip_summary summaries_due[$];   // clip summaries still owed by the block
    int            failures;
    int            samples_sent;
    int            quiet_cycles;
    bit            steady_flow;        // no random idle gaps on either side while set
    int            hold_off_request;   // sink picks this up and holds tready low

    // Shadow of the tracker state, advanced once per accepted sample.
    logic [wat_pkg::MAG_W-1:0] level_line [wat_pkg::WINDOW];
    int unsigned               line_total;      // sum of levels currently in the line
    int unsigned               best_total;      // largest line_total seen at a full window
    logic [wat_pkg::MAG_W-1:0] clip_peak;
    int                        line_fill;       // saturates at WINDOW
    int                        line_slot;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Absolute value of a PCM sample; -32768 pins at full scale.
    function automatic logic [wat_pkg::MAG_W-1:0] sample_level(
        input logic [wat_pkg::IN_TDATA_W-1:0] s
    );
        int v;
        v = $signed(s);
        if (v < 0) v = -v;
        if (v > 32767) v = 32767;
        return wat_pkg::MAG_W'(v);
    endfunction

    function automatic void clear_clip();
        line_total = 0;
        best_total = 0;
        clip_peak  = '0;
        line_fill  = 0;
        line_slot  = 0;
    endfunction

    // Advance the shadow by one accepted sample; queue a summary at clip end.
    function automatic void track_sample(input logic [wat_pkg::IN_TDATA_W-1:0] s,
                                         input logic lst);
        logic [wat_pkg::MAG_W-1:0] lvl;
        t_clip_summary             summary;
        lvl = sample_level(s);
        // Oldest level drops out only once the line has wrapped in this clip.
        if (line_fill >= wat_pkg::WINDOW) line_total -= level_line[line_slot];
        level_line[line_slot] = lvl;
        line_total += lvl;
        line_slot = (line_slot == wat_pkg::WINDOW - 1) ? 0 : line_slot + 1;
        if (line_fill < wat_pkg::WINDOW) line_fill++;
        if (line_fill >= wat_pkg::WINDOW && line_total > best_total) best_total = line_total;
        if (lvl > clip_peak) clip_peak = lvl;
        if (lst) begin
            // Short clip reports all zeros, including the peak.
            summary.enough  = (line_fill >= wat_pkg::WINDOW);
            summary.peak    = summary.enough ? clip_peak : '0;
            summary.average = summary.enough ?
                              wat_pkg::MAG_W'(best_total / wat_pkg::WINDOW) : '0;
            summaries_due.push_back(summary);
            clear_clip();
        end
    endfunction

    // ------------------------------------------------------------------
    // Idle pattern: mostly back-to-back, some short gaps, rare long ones.
    // ------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------

    // Offer one sample and hold it until the request is taken. Called and
    // returns at a falling edge; tvalid is left high so a following call
    // keeps the bus busy without a bubble.
    task automatic send_sample(input logic [wat_pkg::IN_TDATA_W-1:0] s, input logic lst);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        track_sample(s, lst);
        samples_sent++;
        @(negedge i_clk);
    endtask

    // Random sample at a given loudness; a share of full-scale and zero codes
    // keeps the saturation and sign corners busy inside long clips.
    function automatic logic [wat_pkg::IN_TDATA_W-1:0] pick_sample(input int amp);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 4)  return 16'h8000;
        if (r < 7)  return 16'h7fff;
        if (r < 9)  return 16'h8001;
        if (r < 11) return 16'h0000;
        if (amp < 0) return wat_pkg::IN_TDATA_W'($urandom);
        v = int'($urandom_range(0, 2 * amp)) - amp;
        return wat_pkg::IN_TDATA_W'(v);
    endfunction

    // Clip of len samples. Loudness changes every 64 samples so the loudest
    // window lands at different places in the clip.
    task automatic send_clip(input int len);
        int amp;
        int r;
        amp = -1;
        for (int i = 0; i < len; i++) begin
            if (i % 64 == 0) begin
                r = $urandom_range(0, 99);
                if (r < 30)      amp = -1;
                else if (r < 60) amp = $urandom_range(0, 255);
                else             amp = $urandom_range(256, 16383);
            end
            send_sample(pick_sample(amp), i == len - 1);
        end
    endtask

    // Drop tvalid and wait for every owed summary.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (summaries_due.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sink side: tready pattern, with the forced hold-off counted here.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        stall = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request > 0) begin
                stall = hold_off_request;
                hold_off_request = 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
                stall = idle_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted summary against the oldest one owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : summary_check
        t_clip_summary             want;
        logic [wat_pkg::MAG_W-1:0] got_peak;
        logic [wat_pkg::MAG_W-1:0] got_avg;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_peak = o_m_tdata[wat_pkg::MAG_W-1:0];
            got_avg  = o_m_tdata[2*wat_pkg::MAG_W-1:wat_pkg::MAG_W];
            if (summaries_due.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected summary: peak=%0d average=%0d enough=%0b",
                             got_peak, got_avg, o_m_tuser);
            end else begin
                want = summaries_due.pop_front();
                if (got_peak !== want.peak || got_avg !== want.average ||
                        o_m_tuser !== want.enough ||
                        o_m_tdata[wat_pkg::OUT_TDATA_W-1:2*wat_pkg::MAG_W] !== '0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $write("summary mismatch: expected peak=%0d average=%0d enough=%0b",
                               want.peak, want.average, want.enough);
                        $display(", got peak=%0d average=%0d enough=%0b pad=%b",
                                 got_peak, got_avg, o_m_tuser,
                                 o_m_tdata[wat_pkg::OUT_TDATA_W-1:2*wat_pkg::MAG_W]);
                    end
                end
            end
        end
    end

    // Hang detector: no request on either side for too long ends the run.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Clips too short for a window: single-sample clips at the code extremes,
    // then a few slightly longer ones, ending with a walking-bit clip.
    task automatic test_short_clips();
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hffff, 1'b1);
        send_sample(16'h8001, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8001, 1'b0);
        send_sample(16'h7ffe, 1'b1);
        send_sample(16'h5555, 1'b0);
        send_sample(16'haaaa, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'haaaa, 1'b1);
        for (int b = 0; b < wat_pkg::IN_TDATA_W; b += 2)
            send_sample(16'h1 << b, b == wat_pkg::IN_TDATA_W - 2);
        settle();
    endtask

    // Around the window length: one short of full, exactly full, and one that
    // runs past the window so old levels keep dropping out of the sum.
    task automatic test_window_edge();
        send_clip(wat_pkg::WINDOW - 1);
        send_clip(wat_pkg::WINDOW);
        send_clip(wat_pkg::WINDOW + 37);
        settle();
    endtask

    // Full-scale clip: -32768 and +32767 both give the largest level,
    // so the window sum hits its ceiling.
    task automatic test_saturation();
        for (int i = 0; i < wat_pkg::WINDOW + 2; i++)
            send_sample(i[0] ? 16'h7fff : 16'h8000, i == wat_pkg::WINDOW + 1);
        settle();
    endtask

    // Sink holds off while one-sample clips keep coming: the result queue
    // fills and the block has to stall its input.
    task automatic test_pressure();
        steady_flow = 1'b1;
        hold_off_request = HOLD_OFF;
        for (int i = 0; i < 30; i++)
            send_sample(wat_pkg::IN_TDATA_W'($urandom), 1'b1);
        steady_flow = 1'b0;
        settle();
    endtask

    // Short clips so summaries stay frequent, with a share of somewhat
    // longer ones; window-length clips are covered above.
    task automatic test_random_clips();
        int first;
        int clips;
        int r;
        int len;
        first = samples_sent;
        clips = 0;
        while (samples_sent - first < RANDOM_SAMPLES || clips < MIN_RANDOM_CLIPS) begin
            steady_flow = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 15) len = $urandom_range(41, 90);
            else        len = $urandom_range(1, 40);
            send_clip(len);
            clips++;
        end
        steady_flow = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : run
        failures         = 0;
        samples_sent     = 0;
        quiet_cycles     = 0;
        steady_flow      = 1'b0;
        hold_off_request = 0;
        clear_clip();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_clips();
        test_window_edge();
        test_saturation();
        test_pressure();
        test_random_clips();

        // Anything still in flight would show within the result latency.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (summaries_due.size() != 0) failures++;
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
